FILE: design/tcse_pkg.sv
// ----------------------------------------------------------------------------
// tcse_pkg
// Shared types and constants of the TCP connection state engine.
// ----------------------------------------------------------------------------
package tcse_pkg;

    localparam int SOCKETS = 16;
    localparam int SW = (SOCKETS > 1) ? $clog2(SOCKETS) : 1;
    localparam int CW = $clog2(SOCKETS + 1);

    localparam logic [31:0] INIT_SEQ = 32'hBEEFCAFE;
    localparam logic [15:0] FIRST_PORT = 16'd1024;

    localparam logic [5:0] F_FIN = 6'd1;
    localparam logic [5:0] F_SYN = 6'd2;
    localparam logic [5:0] F_RST = 6'd4;
    localparam logic [5:0] F_PSH = 6'd8;
    localparam logic [5:0] F_ACK = 6'd16;

    typedef enum logic [2:0] {
        CMD_RECV = 3'd0,
        CMD_LISTEN = 3'd1,
        CMD_CONNECT = 3'd2,
        CMD_DISCONNECT = 3'd3,
        CMD_SEND = 3'd4
    } cmd_code_t;

    typedef enum logic [2:0] {
        ST_CLOSED = 3'd0,
        ST_LISTEN = 3'd1,
        ST_SYN_SENT = 3'd2,
        ST_SYN_RCVD = 3'd3,
        ST_ESTAB = 3'd4,
        ST_FIN_WAIT1 = 3'd5,
        ST_FIN_WAIT2 = 3'd6,
        ST_CLOSE_WAIT = 3'd7
    } conn_state_t;

    localparam logic [1:0] STATUS_OK = 2'd0;
    localparam logic [1:0] STATUS_FULL = 2'd1;
    localparam logic [1:0] STATUS_NOT_EST = 2'd2;
    localparam logic [1:0] STATUS_NO_MATCH = 2'd3;

    typedef struct packed {
        logic [2:0] cmd;
        logic [3:0] socket_index;
        logic [31:0] peer_ip;
        logic [31:0] own_ip;
        logic [15:0] peer_port;
        logic [15:0] own_port;
        logic [5:0] seg_flags;
        logic [31:0] seg_seq;
        logic [31:0] seg_ack;
        logic [15:0] payload_len;
        logic handler_accept;
    } item_t;

    typedef struct packed {
        logic emit_valid;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [31:0] seq;
        logic [31:0] ack;
        logic [5:0] flags;
        logic [3:0] slot;
        logic [1:0] status;
        logic last;
    } result_t;

    typedef enum logic [2:0] {
        FS_IDLE,
        FS_SCAN,
        FS_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_READ,
        BS_EXEC,
        BS_EMIT1,
        BS_EMIT2
    } back_state_t;

    // Classified command passed from the front to the back.
    typedef struct packed {
        item_t item;
        logic found;
        logic [SW-1:0] slot;
    } job_t;

    // Per-slot control status shared from the back to the front scanner.
    typedef struct packed {
        logic [SOCKETS-1:0] valid;
        logic [SOCKETS*3-1:0] state;
    } slot_ctl_t;

endpackage

FILE: design/tcse_front.sv
// ----------------------------------------------------------------------------
// tcse_front
// Accepts commands and, for receive, listen and connect, scans the slot table one
// entry per cycle while the back is not busy, to find the matching or free slot.
// ----------------------------------------------------------------------------
module tcse_front
    import tcse_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    output logic full,
    input  item_t in_item,
    input  slot_ctl_t ctl,
    input  logic [31:0] tab_own_ip,
    input  logic [15:0] tab_own_port,
    input  logic [31:0] tab_peer_ip,
    input  logic [15:0] tab_peer_port,
    output logic [SW-1:0] tab_addr,
    input  logic back_busy,
    input  logic q_full,
    output logic q_push,
    output job_t q_job
);

    front_state_t state_reg, state_next;
    item_t item_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic found_reg, found_next;
    logic [SW-1:0] slot_reg, slot_next;
    logic [SW-1:0] idx;
    logic hit;
    conn_state_t st_i;

    assign idx = cnt_reg[SW-1:0];
    assign tab_addr = idx;
    assign st_i = conn_state_t'(ctl.state[idx*3 +: 3]);

    always_comb
    begin
        hit = 1'b0;
        if (item_reg.cmd == CMD_RECV) begin
            if (ctl.valid[idx] && tab_own_port == item_reg.own_port
                && tab_own_ip == item_reg.own_ip) begin
                if (st_i == ST_LISTEN
                    && (item_reg.seg_flags & (F_SYN | F_ACK)) == F_SYN)
                    hit = 1'b1;
                else if (tab_peer_port == item_reg.peer_port
                    && tab_peer_ip == item_reg.peer_ip)
                    hit = 1'b1;
            end
        end else begin
            hit = !ctl.valid[idx];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        found_next = found_reg;
        slot_next = slot_reg;
        unique case (state_reg)
            FS_IDLE: begin
                if (push) begin
                    cnt_next = '0;
                    found_next = 1'b0;
                    slot_next = '0;
                    if (in_item.cmd == CMD_RECV || in_item.cmd == CMD_LISTEN
                        || in_item.cmd == CMD_CONNECT)
                        state_next = FS_SCAN;
                    else
                        state_next = FS_PUSH;
                end
            end
            FS_SCAN: begin
                // The table must not change under the scan.
                if (!back_busy) begin
                    if (hit) begin
                        found_next = 1'b1;
                        slot_next = idx;
                        state_next = FS_PUSH;
                    end else if (cnt_reg == CW'(SOCKETS - 1)) begin
                        state_next = FS_PUSH;
                    end else begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            FS_PUSH: begin
                if (!q_full)
                    state_next = FS_IDLE;
            end
            default: state_next = FS_IDLE;
        endcase
    end

    always_comb
    begin
        full = (state_reg != FS_IDLE);
        q_push = (state_reg == FS_PUSH) && !q_full;
        q_job.item = item_reg;
        q_job.found = found_reg;
        q_job.slot = slot_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= FS_IDLE;
            cnt_reg <= '0;
            found_reg <= 1'b0;
            slot_reg <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            found_reg <= found_next;
            slot_reg <= slot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == FS_IDLE && push)
            item_reg <= in_item;
    end

endmodule

FILE: design/tcse_queue.sv
// ----------------------------------------------------------------------------
// tcse_queue
// Two-entry queue of classified commands between the front and the back.
// ----------------------------------------------------------------------------
module tcse_queue
    import tcse_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr,
    input  job_t wdata,
    output logic q_full,
    input  logic rd,
    output logic q_empty,
    output job_t rdata
);

    job_t mem_reg [2];
    logic wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign q_full = (cnt_reg == 2'd2);
    assign q_empty = (cnt_reg == 2'd0);
    assign rdata = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (wr)
                wp_reg <= ~wp_reg;
            if (rd)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr} - {1'b0, rd};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wp_reg] <= wdata;
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !wr) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_empty |-> !rd) else $error("queue underflow");
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3) else $error("queue count out of range");
`endif

endmodule

FILE: design/tcse_back.sv
// ----------------------------------------------------------------------------
// tcse_back
// Holds the socket table and carries out each classified command, producing
// one or two result descriptors.
// ----------------------------------------------------------------------------
module tcse_back
    import tcse_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic q_empty,
    input  job_t q_job,
    output logic q_pop,
    output logic busy,
    output slot_ctl_t ctl,
    input  logic [SW-1:0] tab_addr,
    output logic [31:0] tab_own_ip,
    output logic [15:0] tab_own_port,
    output logic [31:0] tab_peer_ip,
    output logic [15:0] tab_peer_port,
    output logic r_valid,
    output result_t r_data,
    input  logic r_take
);

    back_state_t state_reg, state_next;
    logic [31:0] local_ip_reg;
    logic [15:0] next_port_reg;
    logic [SOCKETS-1:0] valid_reg;
    conn_state_t cst_reg [SOCKETS];
    logic [31:0] own_ip_mem [SOCKETS];
    logic [15:0] own_port_mem [SOCKETS];
    logic [31:0] peer_ip_mem [SOCKETS];
    logic [15:0] peer_port_mem [SOCKETS];
    logic [31:0] seq_mem [SOCKETS];
    logic [31:0] ack_mem [SOCKETS];

    job_t job_reg;
    logic [31:0] r_oip, r_pip, r_seq, r_ack;
    logic [15:0] r_oport, r_pport;
    conn_state_t r_st;
    result_t res1_reg, res2_reg;
    logic two_reg;

    // Execution results, computed in the execute step.
    logic wr_en, wr_valid;
    conn_state_t wr_st;
    logic [31:0] w_oip, w_pip, w_seq, w_ack;
    logic [15:0] w_oport, w_pport;
    logic bump_port;
    result_t e1, e2;
    logic etwo;

    logic [SW-1:0] js;
    logic idx_ok;
    item_t it;

    assign js = job_reg.slot;
    assign it = job_reg.item;
    assign idx_ok = ({1'b0, it.socket_index} < 5'(SOCKETS))
        && valid_reg[it.socket_index[SW-1:0]];

    genvar g;
    generate
        for (g = 0; g < SOCKETS; g++) begin : g_ctl
            assign ctl.state[g*3 +: 3] = cst_reg[g];
        end
    endgenerate
    assign ctl.valid = valid_reg;

    assign tab_own_ip = own_ip_mem[tab_addr];
    assign tab_own_port = own_port_mem[tab_addr];
    assign tab_peer_ip = peer_ip_mem[tab_addr];
    assign tab_peer_port = peer_port_mem[tab_addr];

    function automatic logic [SW-1:0] job_addr();
        return (job_reg.item.cmd == CMD_DISCONNECT || job_reg.item.cmd == CMD_SEND)
            ? job_reg.item.socket_index[SW-1:0] : job_reg.slot;
    endfunction

    always_comb
    begin
        logic [SW-1:0] a;
        logic [5:0] fl;
        logic reset, data;
        conn_state_t st;
        result_t base, h1, h2;
        logic [1:0] n;
        a = (it.cmd == CMD_DISCONNECT || it.cmd == CMD_SEND)
            ? it.socket_index[SW-1:0] : js;
        fl = it.seg_flags;
        reset = 1'b0;
        data = 1'b0;
        n = 2'd0;
        wr_en = 1'b0;
        wr_valid = 1'b1;
        wr_st = r_st;
        w_oip = r_oip;
        w_pip = r_pip;
        w_oport = r_oport;
        w_pport = r_pport;
        w_seq = r_seq;
        w_ack = r_ack;
        bump_port = 1'b0;
        base = '0;
        base.slot = 4'(a);
        base.status = STATUS_OK;
        h1 = base;
        h2 = base;
        st = r_st;
        case (it.cmd)
            CMD_RECV: begin
                if (!job_reg.found) begin
                    base.slot = 4'd0;
                    base.status = STATUS_NO_MATCH;
                    h1 = base;
                    if (!fl[2]) begin
                        h1.emit_valid = 1'b1;
                        h1.src_ip = it.own_ip;
                        h1.dst_ip = it.peer_ip;
                        h1.src_port = it.own_port;
                        h1.dst_port = it.peer_port;
                        h1.seq = it.seg_ack;
                        h1.ack = it.seg_seq + 32'd1;
                        h1.flags = F_RST;
                    end
                end else begin
                    wr_en = 1'b1;
                    if (fl[2])
                        st = ST_CLOSED;
                    if (st != ST_CLOSED) begin
                        case (fl & (F_SYN | F_ACK | F_FIN))
                            F_SYN: begin
                                if (st == ST_LISTEN) begin
                                    st = ST_SYN_RCVD;
                                    w_pport = it.peer_port;
                                    w_pip = it.peer_ip;
                                    w_ack = it.seg_seq + 32'd1;
                                    h1.emit_valid = 1'b1;
                                    h1.seq = INIT_SEQ;
                                    h1.ack = w_ack;
                                    h1.flags = F_SYN | F_ACK;
                                    n = 2'd1;
                                    w_seq = INIT_SEQ + 32'd1;
                                end else
                                    reset = 1'b1;
                            end
                            F_SYN | F_ACK: begin
                                if (st == ST_SYN_SENT) begin
                                    st = ST_ESTAB;
                                    w_ack = it.seg_seq + 32'd1;
                                    w_seq = r_seq + 32'd1;
                                    h1.emit_valid = 1'b1;
                                    h1.seq = w_seq;
                                    h1.ack = w_ack;
                                    h1.flags = F_ACK;
                                    n = 2'd1;
                                end else
                                    reset = 1'b1;
                            end
                            F_SYN | F_FIN, F_SYN | F_FIN | F_ACK: reset = 1'b1;
                            F_FIN, F_FIN | F_ACK: begin
                                if (st == ST_ESTAB) begin
                                    st = ST_CLOSE_WAIT;
                                    w_ack = r_ack + 32'd1;
                                    h1.emit_valid = 1'b1;
                                    h1.seq = r_seq;
                                    h1.ack = w_ack;
                                    h1.flags = F_ACK;
                                    h2 = h1;
                                    h2.flags = F_FIN | F_ACK;
                                    n = 2'd2;
                                end else if (st == ST_CLOSE_WAIT) begin
                                    st = ST_CLOSED;
                                end else if (st == ST_FIN_WAIT1
                                    || st == ST_FIN_WAIT2) begin
                                    st = ST_CLOSED;
                                    w_ack = r_ack + 32'd1;
                                    h1.emit_valid = 1'b1;
                                    h1.seq = r_seq;
                                    h1.ack = w_ack;
                                    h1.flags = F_ACK;
                                    n = 2'd1;
                                end else
                                    reset = 1'b1;
                            end
                            F_ACK: begin
                                if (st == ST_SYN_RCVD)
                                    st = ST_ESTAB;
                                else if (st == ST_FIN_WAIT1)
                                    st = ST_FIN_WAIT2;
                                else if (st == ST_CLOSE_WAIT)
                                    st = ST_CLOSED;
                                else if (fl != F_ACK)
                                    data = 1'b1;
                            end
                            default: data = 1'b1;
                        endcase
                        if (data) begin
                            if (it.seg_seq == r_ack && it.handler_accept) begin
                                w_ack = r_ack + {16'd0, it.payload_len};
                                h1.emit_valid = 1'b1;
                                h1.seq = r_seq;
                                h1.ack = w_ack;
                                h1.flags = F_ACK;
                                n = 2'd1;
                            end else
                                reset = 1'b1;
                        end
                    end
                    if (reset) begin
                        h2 = base;
                        h2.emit_valid = 1'b1;
                        h2.seq = w_seq;
                        h2.ack = w_ack;
                        h2.flags = F_RST;
                        if (n == 2'd0)
                            h1 = h2;
                        n = n + 2'd1;
                    end
                    wr_st = st;
                    wr_valid = (st != ST_CLOSED);
                end
            end
            CMD_LISTEN, CMD_CONNECT: begin
                if (!job_reg.found) begin
                    base.slot = 4'd0;
                    base.status = STATUS_FULL;
                    h1 = base;
                end else begin
                    wr_en = 1'b1;
                    w_oip = local_ip_reg;
                    w_ack = '0;
                    if (it.cmd == CMD_LISTEN) begin
                        wr_st = ST_LISTEN;
                        w_oport = it.own_port;
                        w_pip = '0;
                        w_pport = '0;
                        w_seq = '0;
                    end else begin
                        wr_st = ST_SYN_SENT;
                        w_oport = next_port_reg;
                        w_pip = it.peer_ip;
                        w_pport = it.peer_port;
                        w_seq = INIT_SEQ;
                        bump_port = 1'b1;
                        h1.emit_valid = 1'b1;
                        h1.seq = INIT_SEQ;
                        h1.ack = '0;
                        h1.flags = F_SYN;
                        n = 2'd1;
                    end
                end
            end
            CMD_DISCONNECT: begin
                if (!idx_ok) begin
                    base.slot = 4'd0;
                    base.status = STATUS_NO_MATCH;
                    h1 = base;
                end else begin
                    wr_en = 1'b1;
                    if (r_st == ST_LISTEN) begin
                        wr_st = ST_CLOSED;
                        wr_valid = 1'b0;
                    end else begin
                        wr_st = ST_FIN_WAIT1;
                        h1.emit_valid = 1'b1;
                        h1.seq = r_seq;
                        h1.ack = r_ack;
                        h1.flags = F_FIN | F_ACK;
                        n = 2'd1;
                        w_seq = r_seq + 32'd1;
                    end
                end
            end
            CMD_SEND: begin
                base.slot = it.socket_index;
                if (!idx_ok || r_st != ST_ESTAB) begin
                    base.status = STATUS_NOT_EST;
                    h1 = base;
                end else begin
                    wr_en = 1'b1;
                    h1 = base;
                    h1.emit_valid = 1'b1;
                    h1.seq = r_seq;
                    h1.ack = r_ack;
                    h1.flags = F_PSH | F_ACK;
                    n = 2'd1;
                    w_seq = r_seq + {16'd0, it.payload_len};
                end
            end
            default: h1 = base;
        endcase
        if (h1.emit_valid) begin
            h1.src_ip = (it.cmd == CMD_RECV && !job_reg.found) ? h1.src_ip : w_oip;
            h1.dst_ip = (it.cmd == CMD_RECV && !job_reg.found) ? h1.dst_ip : w_pip;
            h1.src_port = (it.cmd == CMD_RECV && !job_reg.found)
                ? h1.src_port : w_oport;
            h1.dst_port = (it.cmd == CMD_RECV && !job_reg.found)
                ? h1.dst_port : w_pport;
        end
        h2.src_ip = w_oip;
        h2.dst_ip = w_pip;
        h2.src_port = w_oport;
        h2.dst_port = w_pport;
        etwo = (n == 2'd2);
        h1.last = !etwo;
        h2.last = 1'b1;
        e1 = h1;
        e2 = h2;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BS_IDLE: if (!q_empty) state_next = BS_READ;
            BS_READ: state_next = BS_EXEC;
            BS_EXEC: state_next = BS_EMIT1;
            BS_EMIT1: if (r_take) state_next = two_reg ? BS_EMIT2 : BS_IDLE;
            BS_EMIT2: if (r_take) state_next = BS_IDLE;
            default: state_next = BS_IDLE;
        endcase
    end

    // The table is about to change while a queued command waits or one executes.
    always_comb
    begin
        q_pop = (state_reg == BS_IDLE) && !q_empty;
        busy = (state_reg == BS_READ) || (state_reg == BS_EXEC) || !q_empty;
        r_valid = (state_reg == BS_EMIT1) || (state_reg == BS_EMIT2);
        r_data = (state_reg == BS_EMIT2) ? res2_reg : res1_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= BS_IDLE;
            local_ip_reg <= '0;
            next_port_reg <= FIRST_PORT;
            valid_reg <= '0;
            for (int i = 0; i < SOCKETS; i++)
                cst_reg[i] <= ST_CLOSED;
        end else begin
            state_reg <= state_next;
            if (cfg_we)
                local_ip_reg <= cfg_wdata;
            if (state_reg == BS_EXEC) begin
                if (bump_port)
                    next_port_reg <= next_port_reg + 16'd1;
                if (wr_en) begin
                    cst_reg[job_addr()] <= wr_st;
                    valid_reg[job_addr()] <= wr_valid;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            job_reg <= q_job;
        if (state_reg == BS_READ) begin
            r_oip <= own_ip_mem[job_addr()];
            r_oport <= own_port_mem[job_addr()];
            r_pip <= peer_ip_mem[job_addr()];
            r_pport <= peer_port_mem[job_addr()];
            r_seq <= seq_mem[job_addr()];
            r_ack <= ack_mem[job_addr()];
            r_st <= cst_reg[job_addr()];
        end
        if (state_reg == BS_EXEC) begin
            res1_reg <= e1;
            res2_reg <= e2;
            two_reg <= etwo;
            if (wr_en) begin
                own_ip_mem[job_addr()] <= w_oip;
                own_port_mem[job_addr()] <= w_oport;
                peer_ip_mem[job_addr()] <= w_pip;
                peer_port_mem[job_addr()] <= w_pport;
                seq_mem[job_addr()] <= w_seq;
                ack_mem[job_addr()] <= w_ack;
            end
        end
    end

`ifndef SYNTHESIS
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> state_reg == BS_READ) else $error("pop without read");
    a_emit2_last: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BS_EMIT2 |-> r_data.last) else $error("second result not last");
    a_emit1_two: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BS_EMIT1 && two_reg) |-> !r_data.last)
        else $error("first of two marked last");
`endif

endmodule

FILE: design/tcp_connection_state_engine.sv
// ----------------------------------------------------------------------------
// tcp_connection_state_engine
// TCP offload connection state engine with a sixteen-slot socket table.
// ----------------------------------------------------------------------------
// Receive, listen and connect scan the slot table one slot per cycle in the front
// part, while the back is not busy, until the first hit or the last slot; then
// the back part reads the slot, executes and delivers one or two results.
// The front may scan the next command while the back delivers results.
module tcp_connection_state_engine
    import tcse_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic push,
    output logic full,
    input  logic [2:0] cmd,
    input  logic [3:0] socket_index,
    input  logic [31:0] peer_ip,
    input  logic [31:0] own_ip,
    input  logic [15:0] peer_port,
    input  logic [15:0] own_port,
    input  logic [5:0] seg_flags,
    input  logic [31:0] seg_seq,
    input  logic [31:0] seg_ack,
    input  logic [15:0] payload_len,
    input  logic handler_accept,
    output logic empty,
    input  logic pop,
    output logic emit_valid,
    output logic [31:0] out_src_ip,
    output logic [31:0] out_dst_ip,
    output logic [15:0] out_src_port,
    output logic [15:0] out_dst_port,
    output logic [31:0] out_seq,
    output logic [31:0] out_ack,
    output logic [5:0] out_flags,
    output logic [3:0] slot_out,
    output logic [1:0] status,
    output logic last
);

    item_t in_item;
    slot_ctl_t ctl;
    logic [SW-1:0] tab_addr;
    logic [31:0] t_oip, t_pip;
    logic [15:0] t_oport, t_pport;
    logic back_busy, q_full, q_push, q_empty, q_pop, r_valid;
    job_t fj, qj;
    result_t r;

    assign in_item = '{cmd: cmd, socket_index: socket_index, peer_ip: peer_ip,
        own_ip: own_ip, peer_port: peer_port, own_port: own_port,
        seg_flags: seg_flags, seg_seq: seg_seq, seg_ack: seg_ack,
        payload_len: payload_len, handler_accept: handler_accept};

    tcse_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_item(in_item),
        .ctl(ctl), .tab_own_ip(t_oip), .tab_own_port(t_oport),
        .tab_peer_ip(t_pip), .tab_peer_port(t_pport), .tab_addr(tab_addr),
        .back_busy(back_busy), .q_full(q_full), .q_push(q_push), .q_job(fj)
    );

    tcse_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr(q_push), .wdata(fj), .q_full(q_full),
        .rd(q_pop), .q_empty(q_empty), .rdata(qj)
    );

    tcse_back u_back (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .q_empty(q_empty), .q_job(qj), .q_pop(q_pop), .busy(back_busy),
        .ctl(ctl), .tab_addr(tab_addr), .tab_own_ip(t_oip),
        .tab_own_port(t_oport), .tab_peer_ip(t_pip), .tab_peer_port(t_pport),
        .r_valid(r_valid), .r_data(r), .r_take(pop)
    );

    assign empty = !r_valid;
    assign emit_valid = r.emit_valid;
    assign out_src_ip = r.src_ip;
    assign out_dst_ip = r.dst_ip;
    assign out_src_port = r.src_port;
    assign out_dst_port = r.dst_port;
    assign out_seq = r.seq;
    assign out_ack = r.ack;
    assign out_flags = r.flags;
    assign slot_out = r.slot;
    assign status = r.status;
    assign last = r.last;

endmodule
